// File: rtl/core/hmp_pkg.sv
// ----------------------------------------------------------------------------
// hmp_pkg - shared types and constants for the hash message padder
// Block geometry, channel word layouts, control structs and state codes.
// ----------------------------------------------------------------------------
package hmp_pkg;

   localparam int BLK_SIZE        = 64;
   localparam int LEN_BYTES       = 8;
   localparam int WORD_BYTES      = 8;
   localparam int WORD_BITS       = WORD_BYTES * 8;
   localparam int WORDS_PER_BLOCK = (BLK_SIZE + WORD_BYTES - 1) / WORD_BYTES;
   localparam int ADDR_W          = $clog2(BLK_SIZE);
   localparam int POS_W           = $clog2(WORDS_PER_BLOCK * WORD_BYTES);
   localparam int WRD_W           = POS_W - 3;
   localparam int SIDX_W          = $clog2(2 * BLK_SIZE) + 1;
   localparam int LEN_BITS        = LEN_BYTES * 8;
   localparam int FILL_ONE_MAX    = BLK_SIZE - 1 - LEN_BYTES;
   localparam int CNT_W           = $clog2(WORD_BYTES + 1);

   localparam logic [7:0] PAD_MARK = 8'h80;

   localparam logic CMD_DATA      = 1'b0;
   localparam logic CMD_FINISH    = 1'b1;
   localparam logic STATUS_WORD   = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

   typedef struct packed {
      logic       command;
      logic [7:0] data_byte;
   } hmp_req_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] block_word;
      logic [2:0]           word_index;
      logic                 end_of_block;
      logic                 last;
      logic                 status;
   } hmp_rsp_type;

   // one byte slot handed to the word packer
   typedef struct packed {
      logic       valid;
      logic       use_mem;
      logic [7:0] cbyte;
   } hmp_issue_type;

   typedef struct packed {
      logic full;
      logic empty;
   } hmp_pack_stat_type;

   typedef struct packed {
      logic count;
      logic load;
      logic shift;
   } hmp_len_ctl_type;

   typedef struct packed {
      logic [2:0] word_index;
      logic       end_of_block;
      logic       last;
   } hmp_desc_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_EMIT   = 3'b010,
      ST_REJECT = 3'b100
   } hmp_state_type;

   typedef enum logic [1:0] {
      SRC_ZERO,
      SRC_MEM,
      SRC_MARK,
      SRC_LEN
   } hmp_src_type;

endpackage

// File: rtl/core/hmp_byte_store.sv
// ----------------------------------------------------------------------------
// hmp_byte_store - message byte store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module hmp_byte_store
   import hmp_pkg::*;
(
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] store_ff [BLK_SIZE];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/hmp_len_shift.sv
// ----------------------------------------------------------------------------
// hmp_len_shift - message bit length counter
// Counts the length in bits and shifts it out a byte at a time, MSB first.
// ----------------------------------------------------------------------------
module hmp_len_shift
   import hmp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  hmp_len_ctl_type len_ctl,
   output logic [7:0]      len_byte
);

   logic [63:0]         bit_len_ff;
   logic [63:0]         bit_len_in;
   logic [LEN_BITS-1:0] len_sr_ff;
   logic [LEN_BITS-1:0] len_sr_in;

   always_comb begin
      bit_len_in = bit_len_ff;
      if (len_ctl.count) begin
         bit_len_in = bit_len_ff + 64'd8;   // wraps modulo 2^64
      end
   end

   always_comb begin
      len_sr_in = len_sr_ff;
      if (len_ctl.load) begin
         len_sr_in = bit_len_ff[LEN_BITS-1:0];
      end else if (len_ctl.shift) begin
         len_sr_in = len_sr_ff << 8;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_len_ff <= '0;
      end else begin
         bit_len_ff <= bit_len_in;
      end
   end

   always_ff @(posedge clock) begin
      len_sr_ff <= len_sr_in;
   end

   assign len_byte = len_sr_ff[LEN_BITS-1 -: 8];

endmodule

// File: rtl/core/hmp_word_pack.sv
// ----------------------------------------------------------------------------
// hmp_word_pack - byte to word packer
// Lines each byte slot up with the store's read latency and shifts it
// into a 64-bit word, first byte ending up in the top bits.
// ----------------------------------------------------------------------------
module hmp_word_pack
   import hmp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  hmp_issue_type        issue,
   input  logic [7:0]           mem_rdata,
   input  logic                 take,
   output logic [WORD_BITS-1:0] word,
   output hmp_pack_stat_type    pk_stat
);

   hmp_issue_type        stage_ff;
   logic [WORD_BITS-1:0] word_sr_ff;
   logic [WORD_BITS-1:0] word_sr_in;
   logic [CNT_W-1:0]     cnt_ff;
   logic [CNT_W-1:0]     cnt_in;
   logic [7:0]           byte_sel;

   always_comb begin
      byte_sel   = stage_ff.use_mem ? mem_rdata : stage_ff.cbyte;
      word_sr_in = word_sr_ff;
      cnt_in     = cnt_ff;
      if (stage_ff.valid) begin
         word_sr_in = {word_sr_ff[WORD_BITS-9:0], byte_sel};
         cnt_in     = cnt_ff + 1'b1;
      end
      if (take) begin
         cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
         cnt_ff   <= '0;
      end else begin
         stage_ff <= issue;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      word_sr_ff <= word_sr_in;
   end

   assign word          = word_sr_ff;
   assign pk_stat.full  = (cnt_ff == CNT_W'(WORD_BYTES));
   assign pk_stat.empty = (cnt_ff == '0) && !stage_ff.valid;

endmodule

// File: rtl/core/hash_message_padder.sv
// ----------------------------------------------------------------------------
// hash_message_padder - SHA-1 style message padder
// Collects message bytes into 64-byte blocks and emits each full block
// and the padded end of the message as 64-bit words.
// ----------------------------------------------------------------------------
// A data byte that does not complete a block is taken with req_ready
// staying high. A byte that completes a block, and a finish command, start
// a run of output words during which req_ready is low: each word is built
// byte by byte from the byte store or from the mark, zero and length
// bytes, each byte through the packer's stage register that lines it up
// with the store's registered read, and the full word is handed over once
// the output register is free; the next word starts only after that. A
// finish makes one block, or two when the 0x80 mark and the length field
// do not fit behind the message bytes. A word already waiting on the rsp_
// side does not hold off plain data bytes. After a finish, a data byte
// comes back as a single rejected word (status 1) and a second finish produces nothing.
// ----------------------------------------------------------------------------
module hash_message_padder
   import hmp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  hmp_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output hmp_rsp_type rsp_data
);

   hmp_state_type     state_ff, state_in;
   logic [ADDR_W-1:0] fill_ff, fill_in;
   logic              finished_ff, finished_in;
   logic              pad_mode_ff, pad_mode_in;   // 1: padding run, 0: full data block
   logic              blk_ff, blk_in;             // which of the two pad blocks
   logic              two_ff, two_in;             // padding spills into a second block
   logic [POS_W-1:0]  pos_ff, pos_in;             // byte position within block
   logic              iss_hold_ff, iss_hold_in;   // word issued, waiting for hand-over
   logic [SIDX_W-1:0] len_start_ff, len_start_in; // first byte of length field
   hmp_desc_type      desc_ff, desc_in;
   logic              rsp_valid_ff, rsp_valid_in;
   hmp_rsp_type       rsp_data_ff, rsp_data_in;

   logic                 req_fire;
   logic                 out_free;
   logic                 wr_en;
   logic                 rd_en;
   logic                 take;
   logic                 two_need;
   logic                 in_blk;
   logic                 eob;
   logic [SIDX_W-1:0]    sidx;
   hmp_src_type          src;
   hmp_issue_type        issue;
   hmp_len_ctl_type      len_ctl;
   hmp_pack_stat_type    pk_stat;
   logic [7:0]           mem_rdata;
   logic [7:0]           len_byte;
   logic [WORD_BITS-1:0] pk_word;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign two_need  = (SIDX_W'(fill_ff) > SIDX_W'(FILL_ONE_MAX));

   // --- byte source for the current issue position -------------------------
   always_comb begin
      sidx   = blk_ff ? (SIDX_W'(BLK_SIZE) + SIDX_W'(pos_ff)) : SIDX_W'(pos_ff);
      in_blk = ({1'b0, pos_ff} < (POS_W + 1)'(BLK_SIZE));
      eob    = (pos_ff[POS_W-1:3] == WRD_W'(WORDS_PER_BLOCK - 1));
      priority if (!in_blk) begin
         src = SRC_ZERO;            // tail of a short last word
      end else if (!pad_mode_ff) begin
         src = SRC_MEM;
      end else if (sidx < SIDX_W'(fill_ff)) begin
         src = SRC_MEM;
      end else if (sidx == SIDX_W'(fill_ff)) begin
         src = SRC_MARK;
      end else if (sidx >= len_start_ff) begin
         src = SRC_LEN;
      end else begin
         src = SRC_ZERO;
      end
   end

   // --- sequencer ------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      finished_in  = finished_ff;
      pad_mode_in  = pad_mode_ff;
      blk_in       = blk_ff;
      two_in       = two_ff;
      pos_in       = pos_ff;
      iss_hold_in  = iss_hold_ff;
      len_start_in = len_start_ff;
      desc_in      = desc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      take         = 1'b0;
      issue        = '0;
      len_ctl      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_data.command == CMD_DATA) begin
                  if (finished_ff) begin
                     state_in = ST_REJECT;
                  end else begin
                     wr_en         = 1'b1;
                     len_ctl.count = 1'b1;
                     if (fill_ff == ADDR_W'(BLK_SIZE - 1)) begin
                        // block complete: stream it out
                        fill_in     = '0;
                        state_in    = ST_EMIT;
                        pad_mode_in = 1'b0;
                        blk_in      = 1'b0;
                        two_in      = 1'b0;
                        pos_in      = '0;
                        iss_hold_in = 1'b0;
                     end else begin
                        fill_in = fill_ff + 1'b1;
                     end
                  end
               end else if (!finished_ff) begin
                  finished_in  = 1'b1;
                  len_ctl.load = 1'b1;
                  state_in     = ST_EMIT;
                  pad_mode_in  = 1'b1;
                  blk_in       = 1'b0;
                  two_in       = two_need;
                  pos_in       = '0;
                  iss_hold_in  = 1'b0;
                  len_start_in = two_need ? SIDX_W'(2 * BLK_SIZE - LEN_BYTES)
                                          : SIDX_W'(BLK_SIZE - LEN_BYTES);
               end
            end
         end

         ST_EMIT: begin
            if (!iss_hold_ff) begin
               rd_en         = 1'b1;
               issue.valid   = 1'b1;
               issue.use_mem = (src == SRC_MEM);
               issue.cbyte   = (src == SRC_MARK) ? PAD_MARK :
                               (src == SRC_LEN)  ? len_byte : 8'h00;
               len_ctl.shift = (src == SRC_LEN);
               if (pos_ff[2:0] == 3'b111) begin
                  iss_hold_in          = 1'b1;
                  desc_in.word_index   = 3'(pos_ff[POS_W-1:3]);
                  desc_in.end_of_block = eob;
                  desc_in.last         = eob && (blk_ff == two_ff);
                  if (eob) begin
                     pos_in = '0;
                     blk_in = 1'b1;
                  end else begin
                     pos_in = pos_ff + 1'b1;
                  end
               end else begin
                  pos_in = pos_ff + 1'b1;
               end
            end
            if (pk_stat.full && out_free) begin
               take                     = 1'b1;
               iss_hold_in              = 1'b0;
               rsp_valid_in             = 1'b1;
               rsp_data_in.block_word   = pk_word;
               rsp_data_in.word_index   = desc_ff.word_index;
               rsp_data_in.end_of_block = desc_ff.end_of_block;
               rsp_data_in.last         = desc_ff.last;
               rsp_data_in.status       = STATUS_WORD;
               if (desc_ff.last) begin
                  state_in = ST_IDLE;
               end
            end
         end

         ST_REJECT: begin
            if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.block_word   = '0;
               rsp_data_in.word_index   = '0;
               rsp_data_in.end_of_block = 1'b0;
               rsp_data_in.last         = 1'b1;
               rsp_data_in.status       = STATUS_REJECT;
               state_in                 = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         finished_ff  <= 1'b0;
         iss_hold_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         finished_ff  <= finished_in;
         iss_hold_ff  <= iss_hold_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // run context and result payload: loaded before use
   always_ff @(posedge clock) begin
      pad_mode_ff  <= pad_mode_in;
      blk_ff       <= blk_in;
      two_ff       <= two_in;
      pos_ff       <= pos_in;
      len_start_ff <= len_start_in;
      desc_ff      <= desc_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // --- datapath -------------------------------------------------------------
   hmp_byte_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (fill_ff),
      .wr_data (req_data.data_byte),
      .rd_en   (rd_en),
      .rd_addr (pos_ff[ADDR_W-1:0]),
      .rd_data (mem_rdata)
   );

   hmp_len_shift u_len (
      .clock    (clock),
      .reset    (reset),
      .len_ctl  (len_ctl),
      .len_byte (len_byte)
   );

   hmp_word_pack u_pack (
      .clock     (clock),
      .reset     (reset),
      .issue     (issue),
      .mem_rdata (mem_rdata),
      .take      (take),
      .word      (pk_word),
      .pk_stat   (pk_stat)
   );

   // --- checks ---------------------------------------------------------------
   a_idle_pack_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_EMIT) |-> pk_stat.empty)
      else $error("word packer holds bytes outside an output run");

   a_full_only_held: assert property (@(posedge clock) disable iff (reset)
      pk_stat.full |-> (iss_hold_ff && (state_ff == ST_EMIT)))
      else $error("word packer full while issue still running");

   a_finished_sticks: assert property (@(posedge clock) disable iff (reset)
      finished_ff |=> finished_ff)
      else $error("finished flag cleared without reset");

   a_reject_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff.status == STATUS_REJECT)) |->
         (rsp_data_ff.last && (rsp_data_ff.block_word == '0) &&
          !rsp_data_ff.end_of_block))
      else $error("rejected word carries block data");

endmodule

// File: sim/tb_hash_message_padder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hash_message_padder - self-checking bench for the hash message padder
// Streams one message of random length and content through the padder, then
// the closing finish, then a run of late data words and repeated finishes.
// Every output word is checked field by field against a behavioural padder
// kept inside the bench, under shifting back-pressure on both channels.
// ----------------------------------------------------------------------------
module tb_hash_message_padder;
   import hmp_pkg::*;

   // No handshake for this long means the block has hung. The slowest
   // legal gap is one output word built byte by byte plus a long
   // receiver stall, so this is many times over.
   localparam int WATCHDOG_LIMIT = 5000;
   // Quiet time after the last expected word, to catch stray output.
   localparam int SETTLE_CYCLES  = 100;
   // Late words after the finish: rejects and ignored finishes.
   localparam int LATE_WORDS     = 76;

   // An input word waiting to be driven; hold makes the driver pause until
   // every output word predicted so far has been received.
   typedef struct packed {
      logic        hold;
      hmp_req_type word;
   } pending_word_type;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   hmp_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   hmp_rsp_type rsp_data;

   // Bench copy of the padder state.
   logic [7:0]  msg_bytes [BLK_SIZE];
   logic [7:0]  pad_buf [2*BLK_SIZE];
   int          fill_level  = 0;
   logic [63:0] msg_bit_len = '0;
   logic        msg_closed  = 1'b0;

   hmp_rsp_type      expected_words [$];
   pending_word_type pending_words [$];
   hmp_rsp_type      expected_now;

   int total_items    = 0;
   int words_taken    = 0;   // input words accepted (nonblocking)
   int results_due    = 0;   // output words predicted (driver only)
   int results_seen   = 0;   // output words received (nonblocking)
   int mismatch_count = 0;
   int stall_cycles   = 0;

   hash_message_padder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Padder prediction
   // ------------------------------------------------------------------------

   // Queue one block of pad_buf, starting at base, as output words. The
   // first byte lands in the top bits; bytes past the block end read as 0.
   task automatic push_block(input int base, input logic final_block);
      hmp_rsp_type w;
      int          idx;
      for (int n = 0; n < WORDS_PER_BLOCK; n++) begin
         w = '0;
         for (int b = 0; b < WORD_BYTES; b++) begin
            idx = n * WORD_BYTES + b;
            w.block_word = {w.block_word[WORD_BITS-9:0],
                            (idx < BLK_SIZE) ? pad_buf[base + idx] : 8'h00};
         end
         w.word_index   = 3'(n);
         w.end_of_block = (n == WORDS_PER_BLOCK - 1);
         w.last         = final_block && (n == WORDS_PER_BLOCK - 1);
         w.status       = STATUS_WORD;
         expected_words.push_back(w);
         results_due++;
      end
   endtask

   task automatic predict_padded_words(input hmp_req_type w);
      int          pos;
      int          total;
      hmp_rsp_type rej;
      if (w.command == CMD_DATA) begin
         if (msg_closed) begin
            // data after the finish: a lone reject, state untouched
            rej        = '0;
            rej.last   = 1'b1;
            rej.status = STATUS_REJECT;
            expected_words.push_back(rej);
            results_due++;
         end else begin
            msg_bytes[fill_level] = w.data_byte;
            fill_level++;
            msg_bit_len += 64'd8;
            if (fill_level == BLK_SIZE) begin
               fill_level = 0;
               for (int i = 0; i < BLK_SIZE; i++)
                  pad_buf[i] = msg_bytes[i];
               push_block(0, 1'b1);
            end
         end
      end else if (!msg_closed) begin
         // mark byte, zero fill, then the bit count big-endian at the tail;
         // spills into a second block when the count no longer fits
         pos = fill_level;
         for (int i = 0; i < pos; i++)
            pad_buf[i] = msg_bytes[i];
         pad_buf[pos] = PAD_MARK;
         pos++;
         total = (pos + LEN_BYTES <= BLK_SIZE) ? BLK_SIZE : 2 * BLK_SIZE;
         while (pos < total - LEN_BYTES) begin
            pad_buf[pos] = 8'h00;
            pos++;
         end
         for (int i = 0; i < LEN_BYTES; i++) begin
            pad_buf[pos] = 8'(msg_bit_len >> (8 * (LEN_BYTES - 1 - i)));
            pos++;
         end
         push_block(0, total == BLK_SIZE);
         if (total != BLK_SIZE)
            push_block(BLK_SIZE, 1'b1);
         msg_closed = 1'b1;
      end
      // a finish after the finish produces nothing
   endtask

   // ------------------------------------------------------------------------
   // Back-pressure phases, stepped by the number of input words taken:
   // receiver lazy first, then sender lazy, then both flat out.
   // ------------------------------------------------------------------------
   function automatic int idle_phase();
      if (words_taken < total_items / 3)
         return 0;
      else if (words_taken < 2 * total_items / 3)
         return 1;
      return 2;
   endfunction

   function automatic int sender_idle_pct();
      case (idle_phase())
         0: return 15;
         1: return 59;
         default: return 0;
      endcase
   endfunction

   function automatic int receiver_idle_pct();
      case (idle_phase())
         0: return 59;
         1: return 15;
         default: return 0;
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Driver: predicts on each accepted word, then offers the next one only
   // when the channel is free, so valid never drops before acceptance.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_padded_words(req_data);
            words_taken <= words_taken + 1;
         end
         if (!req_valid || req_ready) begin
            if (pending_words.size() != 0 &&
                !(pending_words[0].hold && results_seen < results_due) &&
                $urandom_range(99) >= sender_idle_pct()) begin
               req_data  <= pending_words[0].word;
               req_valid <= 1'b1;
               void'(pending_words.pop_front());
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: random ready, field-by-field comparison with the oldest
   // prediction.
   // ------------------------------------------------------------------------
   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_idle_pct());
         if (rsp_valid && rsp_ready) begin
            results_seen <= results_seen + 1;
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected word, expected none, actual %h", $time, rsp_data);
               mismatch_count++;
            end else begin
               expected_now = expected_words.pop_front();
               check_field("block_word", expected_now.block_word, rsp_data.block_word);
               check_field("word_index", 64'(expected_now.word_index),
                           64'(rsp_data.word_index));
               check_field("end_of_block", 64'(expected_now.end_of_block),
                           64'(rsp_data.end_of_block));
               check_field("last", 64'(expected_now.last), 64'(rsp_data.last));
               check_field("status", 64'(expected_now.status), 64'(rsp_data.status));
            end
         end
      end
   end

   // Watchdog: restarts on any handshake.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog, no handshake for %0d cycles", $time, stall_cycles);
         $display("TB_ERROR");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus and end of run
   // ------------------------------------------------------------------------
   task automatic queue_word(input logic cmd, input logic [7:0] data_byte,
                             input logic hold);
      pending_word_type p;
      p.hold           = hold;
      p.word.command   = cmd;
      p.word.data_byte = data_byte;
      pending_words.push_back(p);
   endtask

   initial begin
      int fill_target;
      int msg_len;

      // Reset is applied once only, so there is a single message per run.
      // Half the runs end it near the block tail, where the length field
      // no longer fits and the finish spills into a second block.
      if ($urandom_range(1) == 1)
         fill_target = $urandom_range(BLK_SIZE - 1, FILL_ONE_MAX + 1);
      else
         fill_target = $urandom_range(FILL_ONE_MAX, 0);
      msg_len = 4 * BLK_SIZE + fill_target;

      // directed opening bytes: extremes and alternating bit patterns
      queue_word(CMD_DATA, 8'h00, 1'b0);
      queue_word(CMD_DATA, 8'hff, 1'b0);
      queue_word(CMD_DATA, PAD_MARK, 1'b0);
      queue_word(CMD_DATA, 8'h7f, 1'b0);
      queue_word(CMD_DATA, 8'h01, 1'b0);
      queue_word(CMD_DATA, 8'hfe, 1'b0);
      queue_word(CMD_DATA, 8'h55, 1'b0);
      queue_word(CMD_DATA, 8'haa, 1'b0);

      // rest of the message; pause after the opening bytes and for a drained block mid-way
      for (int i = 8; i < msg_len; i++)
         queue_word(CMD_DATA, 8'($urandom), (i == 8) || (i == 2 * BLK_SIZE));

      // close the message with nothing outstanding; data bits are don't-care
      queue_word(CMD_FINISH, 8'($urandom), 1'b1);

      // after the finish: data is rejected, a second finish is silent
      queue_word(CMD_DATA, 8'h00, 1'b0);
      queue_word(CMD_FINISH, 8'hff, 1'b0);
      queue_word(CMD_DATA, 8'hff, 1'b0);
      for (int i = 0; i < LATE_WORDS; i++)
         queue_word(($urandom_range(99) < 25) ? CMD_FINISH : CMD_DATA, 8'($urandom), 1'b0);

      total_items = pending_words.size();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (!(words_taken == total_items && results_seen >= results_due))
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_words.size() == 0) begin
         $display("TB_OK");
      end else begin
         if (expected_words.size() != 0)
            $display("%0t: %0d expected words never arrived", $time, expected_words.size());
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/core/hmp_pkg.sv
rtl/core/hmp_byte_store.sv
rtl/core/hmp_len_shift.sv
rtl/core/hmp_word_pack.sv
rtl/core/hash_message_padder.sv
sim/tb_hash_message_padder.sv
